[rtl/core/sia_pkg.sv]
`default_nettype none
package sia_pkg;

    // radix codes on the input channel
    localparam logic [2:0] RC_DEC     = 3'd0;
    localparam logic [2:0] RC_HEX     = 3'd1;
    localparam logic [2:0] RC_BIN     = 3'd2;
    localparam logic [2:0] RC_OCT     = 3'd3;
    localparam logic [2:0] RC_UNKNOWN = 3'd4;

    // ASCII characters
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [3:0] DIGIT_TEN = 4'd10;

    // recognized radix, selects the digit width of the shift register
    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_BIN,
        RX_OCT
    } t_radix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIG,
        S_ERR
    } t_state;

    // control from the sequencer to the digit shift register
    typedef struct packed {
        logic   load;
        logic   shift;
        t_radix kind;
    } t_sreg_ctrl;

    // map one digit value to its ASCII character, uppercase for A-F
    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] ch;
        if (d < DIGIT_TEN) begin
            ch = CH_ZERO + {4'b0, d};
        end else begin
            ch = CH_UPPER_A + {4'b0, d - DIGIT_TEN};
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

[rtl/core/sia_bcd_conv.sv]
`default_nettype none
module sia_bcd_conv import sia_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_load,
    input  wire logic                      i_step,
    input  wire logic [VALUE_BITS-1:0]     i_bin,
    output logic      [4*NUM_DIGITS-1:0]   o_bcd
);

    logic [VALUE_BITS-1:0]   r_bin;
    logic [4*NUM_DIGITS-1:0] r_bcd;
    logic [4*NUM_DIGITS-1:0] adj_bcd;

    // add three to every BCD digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj_bcd[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // shift one binary bit into the BCD word per step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (i_step) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= {adj_bcd[4*NUM_DIGITS-2:0], r_bin[VALUE_BITS-1]};
        end
    end

    assign o_bcd = r_bcd;

endmodule
`default_nettype wire

[rtl/core/sia_digit_sreg.sv]
`default_nettype none
module sia_digit_sreg import sia_pkg::*; #(
    parameter int SREG_BITS = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_sreg_ctrl            i_ctrl,
    input  wire logic [SREG_BITS-1:0]  i_data,
    output logic      [3:0]            o_digit,
    output logic                       o_rem_one
);

    localparam int REM_W = $clog2(SREG_BITS + 1);

    logic [SREG_BITS-1:0] r_sreg;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     n_rem;
    t_radix               r_kind;

    // digit slots per radix
    always_comb begin
        case (i_ctrl.kind)
            RX_DEC:  n_rem = REM_W'(SREG_BITS / 4);
            RX_HEX:  n_rem = REM_W'(SREG_BITS / 4);
            RX_OCT:  n_rem = REM_W'(SREG_BITS / 3);
            RX_BIN:  n_rem = REM_W'(SREG_BITS);
            default: n_rem = REM_W'(SREG_BITS);
        endcase
    end

    // load the word, then advance one digit per shift
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sreg <= i_data;
            r_kind <= i_ctrl.kind;
        end else if (i_ctrl.shift) begin
            case (r_kind)
                RX_DEC:  r_sreg <= {r_sreg[SREG_BITS-5:0], 4'b0};
                RX_HEX:  r_sreg <= {r_sreg[SREG_BITS-5:0], 4'b0};
                RX_OCT:  r_sreg <= {r_sreg[SREG_BITS-4:0], 3'b0};
                RX_BIN:  r_sreg <= {r_sreg[SREG_BITS-2:0], 1'b0};
                default: r_sreg <= r_sreg;
            endcase
        end
    end

    // count the digit slots still in the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_ctrl.load) begin
            r_rem <= n_rem;
        end else if (i_ctrl.shift) begin
            r_rem <= r_rem - REM_W'(1);
        end
    end

    // present the top digit right-aligned
    always_comb begin
        case (r_kind)
            RX_DEC:  o_digit = r_sreg[SREG_BITS-1 -: 4];
            RX_HEX:  o_digit = r_sreg[SREG_BITS-1 -: 4];
            RX_OCT:  o_digit = {1'b0, r_sreg[SREG_BITS-1 -: 3]};
            RX_BIN:  o_digit = {3'b0, r_sreg[SREG_BITS-1]};
            default: o_digit = 4'b0;
        endcase
    end

    assign o_rem_one = (r_rem == REM_W'(1));

endmodule
`default_nettype wire

[rtl/core/signed_integer_to_ascii_radix_unit.sv]
`default_nettype none
// Signed integer to ASCII text in radix 10, 16, 2 or 8.
// Input: pulse start with i_value and i_radix_code while busy is low; the
// transaction is taken at that edge and busy stays high until the last
// character has left. Output: one character per o_valid strobe, each held
// for exactly one cycle: a sign ('+' or '-'), then the digits of the
// magnitude, most significant first, uppercase A-F; o_last marks the final
// one. Zero gives "+0"; an unrecognized radix with a nonzero value gives one
// NUL character with o_ok low.
// Sequence: hex, octal and binary load the magnitude straight into the digit
// shift register; decimal first runs a shift-add-3 BCD conversion over all
// VALUE_BITS bits of the magnitude. After that comes the sign state, then the
// digit state, which shifts through every digit slot of the shift register,
// leading zero slots being dropped silently. With VALUE_BITS = 32 the
// register holds 48 bits; the next transaction can be taken at the edge
// where busy is low. The error case gives its one character from the error
// state and then returns to idle. Reset clears the sequencer to idle.
// The receiver cannot stall; characters leave as they are formed.
module signed_integer_to_ascii_radix_unit import sia_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic        [2:0]            i_radix_code,
    output logic                              busy,
    output logic                              o_valid,
    output logic             [7:0]            o_digit_char,
    output logic                              o_last,
    output logic                              o_ok
);

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int SREG_BITS  = ((4 * NUM_DIGITS + 11) / 12) * 12;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_started;
    logic                  r_neg;
    t_radix                r_kind;

    logic                  accept;
    logic [VALUE_BITS-1:0] mag;
    logic                  dec_err;
    t_radix                dec_kind;
    logic [4*NUM_DIGITS-1:0] bcd;
    logic [SREG_BITS-1:0]  sreg_data;
    t_sreg_ctrl            sreg_ctrl;
    logic [3:0]            digit;
    logic                  rem_one;
    logic                  skipping;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // magnitude as an unsigned value
    assign mag = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    // decode the radix; zero always converts through the hex path
    always_comb begin
        dec_err  = 1'b0;
        dec_kind = RX_HEX;
        if (mag != '0) begin
            case (i_radix_code)
                RC_DEC:  dec_kind = RX_DEC;
                RC_HEX:  dec_kind = RX_HEX;
                RC_BIN:  dec_kind = RX_BIN;
                RC_OCT:  dec_kind = RX_OCT;
                default: dec_err  = 1'b1;
            endcase
        end
    end

    // hold the transaction's sign and radix
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg  <= i_value[VALUE_BITS-1];
            r_kind <= dec_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (dec_err) begin
                        n_state = S_ERR;
                    end else if (dec_kind == RX_DEC) begin
                        n_state = S_CONV;
                    end else begin
                        n_state = S_SIGN;
                    end
                end
            end
            S_CONV: begin
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: n_state = S_DIG;
            S_DIG: begin
                if (rem_one) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // count BCD conversion steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= '0;
        end else if (r_state == S_CONV) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // mark the first nonzero digit; drop leading zeros before it
    assign skipping = (r_state == S_DIG) && !r_started && (digit == 4'b0) && !rem_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (accept) begin
            r_started <= 1'b0;
        end else if ((r_state == S_DIG) && !skipping) begin
            r_started <= 1'b1;
        end
    end

    // shift register control
    always_comb begin
        sreg_ctrl.load  = (accept && (dec_kind != RX_DEC))
                       || ((r_state == S_SIGN) && (r_kind == RX_DEC));
        sreg_ctrl.shift = (r_state == S_DIG);
        sreg_ctrl.kind  = accept ? dec_kind : r_kind;
        sreg_data       = accept ? SREG_BITS'(mag) : SREG_BITS'(bcd);
    end

    sia_bcd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_step (r_state == S_CONV),
        .i_bin  (mag),
        .o_bcd  (bcd)
    );

    sia_digit_sreg #(
        .SREG_BITS (SREG_BITS)
    ) u_sreg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (sreg_ctrl),
        .i_data    (sreg_data),
        .o_digit   (digit),
        .o_rem_one (rem_one)
    );

    // outputs
    always_comb begin
        o_valid      = 1'b0;
        o_digit_char = CH_NUL;
        o_last       = 1'b0;
        o_ok         = 1'b1;
        case (r_state)
            S_SIGN: begin
                o_valid      = 1'b1;
                o_digit_char = r_neg ? CH_MINUS : CH_PLUS;
            end
            S_DIG: begin
                o_valid      = !skipping;
                o_digit_char = digit_to_ascii(digit);
                o_last       = rem_one;
            end
            S_ERR: begin
                o_valid = 1'b1;
                o_last  = 1'b1;
                o_ok    = 1'b0;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

[tb/sia_char_checker.sv]
`timescale 1ns / 100ps
module sia_char_checker import sia_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] i_value,
    input  wire logic [2:0]  i_radix_code,
    input  wire logic        o_valid,
    input  wire logic [7:0]  o_digit_char,
    input  wire logic        o_last,
    input  wire logic        o_ok,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_char_count
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       ok;
    } t_char;

    t_char char_queue[$];
    int    fail_cnt = 0;
    int    char_cnt = 0;

    // ASCII text of one digit value, uppercase letters above nine
    function automatic logic [7:0] ascii_of_digit(input logic [31:0] d);
        logic [7:0] ch;
        if (d < 32'd10) begin
            ch = CH_ZERO + d[7:0];
        end else begin
            ch = CH_UPPER_A + (d[7:0] - 8'd10);
        end
        return ch;
    endfunction

    // Append the characters one conversion must produce
    function automatic void queue_conversion(input logic [31:0] v, input logic [2:0] code);
        logic [31:0] mag;
        logic [31:0] base;
        logic [7:0]  digs[32];
        int          n;
        logic        known;
        mag   = v[31] ? (~v + 32'd1) : v;
        n     = 0;
        known = 1'b1;
        base  = 32'd10;
        // zero gives "+0" whatever the radix
        if (mag == 32'd0) begin
            char_queue.push_back('{ch: CH_PLUS, last: 1'b0, ok: 1'b1});
            char_queue.push_back('{ch: CH_ZERO, last: 1'b1, ok: 1'b1});
            return;
        end
        case (code)
            RC_DEC: base = 32'd10;
            RC_HEX: base = 32'd16;
            RC_BIN: base = 32'd2;
            RC_OCT: base = 32'd8;
            default: known = 1'b0;
        endcase
        // unrecognized radix: single NUL character with ok low
        if (!known) begin
            char_queue.push_back('{ch: CH_NUL, last: 1'b1, ok: 1'b0});
            return;
        end
        // collect digits least significant first
        while (mag != 32'd0) begin
            digs[n] = ascii_of_digit(mag % base);
            mag     = mag / base;
            n++;
        end
        char_queue.push_back('{ch: v[31] ? CH_MINUS : CH_PLUS, last: 1'b0, ok: 1'b1});
        for (int k = n - 1; k >= 0; k--) begin
            char_queue.push_back('{ch: digs[k], last: (k == 0), ok: 1'b1});
        end
    endfunction

    function automatic void report_fail(input string what, input t_char want, input t_char got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("char error (%s) at char %0d, t=%0t:", what, char_cnt, $time);
            $display("    expected ch=%h last=%b ok=%b, got ch=%h last=%b ok=%b",
                     want.ch, want.last, want.ok, got.ch, got.last, got.ok);
        end
    endfunction

    // Predict on each accepted transaction, compare each strobed character
    always @(posedge i_clk) begin
        t_char got;
        t_char want;
        if (i_rst_n) begin
            if (start && !busy) begin
                queue_conversion(i_value, i_radix_code);
            end
            if (o_valid) begin
                got = '{ch: o_digit_char, last: o_last, ok: o_ok};
                if (char_queue.size() == 0) begin
                    report_fail("unexpected", '0, got);
                end else begin
                    want = char_queue.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last || got.ok !== want.ok) begin
                        report_fail("field", want, got);
                    end
                end
                char_cnt++;
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= char_queue.size();
        o_char_count <= char_cnt;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
    import sia_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 87;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [31:0] i_value      = '0;
    logic [2:0]  i_radix_code = RC_DEC;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_digit_char;
    logic        o_last;
    logic        o_ok;

    int fail_count;
    int pending;
    int char_count;
    int item_count = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    signed_integer_to_ascii_radix_unit #(.VALUE_BITS(32)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .i_radix_code (i_radix_code),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_ok         (o_ok)
    );

    sia_char_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_radix_code (i_radix_code),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_ok         (o_ok),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_char_count (char_count)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_integer_to_ascii_radix_unit: mismatch");
            $finish;
        end
    end

    // Hold start until the transaction is taken, then maybe idle with noise on the bus
    task automatic send_conversion(input logic [31:0] v, input logic [2:0] code,
                                   input int idle_pct);
        start        <= 1'b1;
        i_value      <= v;
        i_radix_code <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        item_count++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do begin
                i_value      <= $urandom;
                i_radix_code <= 3'($urandom_range(7));
                @(posedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Mix of small, full-range, shortened and extreme values
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = $urandom_range(20);
            1: v = -$urandom_range(1, 20);
            2, 3, 4: v = $urandom;
            5: v = $urandom >> $urandom_range(31);
            6: v = -($urandom >> $urandom_range(31));
            default: begin
                case ($urandom_range(5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'd0;
                    4: v = 32'd1_000_000_000;
                    default: v = 32'd1 << $urandom_range(31);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pick_radix();
        logic [2:0] code;
        if ($urandom_range(99) < 85) begin
            code = 3'($urandom_range(3));
        end else begin
            code = 3'($urandom_range(7));
        end
        return code;
    endfunction

    initial begin
        int idle_pct[4];
        idle_pct = '{0, 56, 0, 8};

        // hold reset, then release
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero in several radices, unrecognized ones too
        send_conversion(32'd0, RC_DEC, 0);
        send_conversion(32'd0, RC_HEX, 0);
        send_conversion(32'd0, RC_BIN, 0);
        send_conversion(32'd0, RC_UNKNOWN, 0);
        send_conversion(32'd0, 3'd7, 0);
        // most negative value in every radix
        send_conversion(32'h8000_0000, RC_DEC, 0);
        send_conversion(32'h8000_0000, RC_HEX, 0);
        send_conversion(32'h8000_0000, RC_BIN, 0);
        send_conversion(32'h8000_0000, RC_OCT, 0);
        // most positive value
        send_conversion(32'h7FFF_FFFF, RC_DEC, 0);
        send_conversion(32'h7FFF_FFFF, RC_HEX, 0);
        send_conversion(32'h7FFF_FFFF, RC_BIN, 0);
        send_conversion(32'h7FFF_FFFF, RC_OCT, 0);
        // minus one and one
        send_conversion(32'hFFFF_FFFF, RC_DEC, 0);
        send_conversion(32'hFFFF_FFFF, RC_OCT, 0);
        send_conversion(32'd1, RC_BIN, 0);
        send_conversion(32'd9, RC_DEC, 0);
        // hex letters
        send_conversion(32'h00AB_CDEF, RC_HEX, 0);
        send_conversion(32'd255, RC_HEX, 0);
        // nonzero with unrecognized radix codes
        send_conversion(32'd123, RC_UNKNOWN, 0);
        send_conversion(-32'd5, 3'd5, 0);
        send_conversion(32'd77, 3'd6, 0);
        send_conversion(32'h8000_0000, 3'd7, 0);

        // random phases: the first and third run back to back, the second and fourth idle at different rates
        for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_conversion(pick_value(), pick_radix(), idle_pct[p]);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        // drain the remaining characters
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d conversions, %0d characters checked", item_count, char_count);
        $display("covered all radix codes, zero, extremes and four pacing phases");
        if (fail_count == 0 && pending == 0) begin
            $display("signed_integer_to_ascii_radix_unit: match");
        end else begin
            $display("signed_integer_to_ascii_radix_unit: mismatch");
        end
        $finish;
    end

endmodule
